>>> design/mtm_pkg.sv
package mtm_pkg;

	localparam int TRACKS = 16;

	// Result status codes.
	localparam logic [2:0] ST_DATA     = 3'd0;
	localparam logic [2:0] ST_FINISHED = 3'd1;
	localparam logic [2:0] ST_BAD_SYS  = 3'd2;
	localparam logic [2:0] ST_BAD_CTL  = 3'd3;
	localparam logic [2:0] ST_ILLEGAL  = 3'd4;
	localparam logic [2:0] ST_NO_END   = 3'd5;
	localparam logic [2:0] ST_IGNORED  = 3'd6;

	// Input actions.
	localparam logic [1:0] ACT_START = 2'd0;
	localparam logic [1:0] ACT_BYTE  = 2'd1;
	localparam logic [1:0] ACT_END   = 2'd2;

	// Parser phases.
	localparam logic [1:0] PH_EVENT = 2'd0;
	localparam logic [1:0] PH_OP1   = 2'd1;
	localparam logic [1:0] PH_OP2   = 2'd2;
	localparam logic [1:0] PH_TIME  = 2'd3;

	// MUS event kinds.
	localparam logic [2:0] EV_RELEASE = 3'd0;
	localparam logic [2:0] EV_PLAY    = 3'd1;
	localparam logic [2:0] EV_BEND    = 3'd2;
	localparam logic [2:0] EV_SYSTEM  = 3'd3;
	localparam logic [2:0] EV_CONTROL = 3'd4;
	localparam logic [2:0] EV_BAD5    = 3'd5;
	localparam logic [2:0] EV_SCOREND = 3'd6;
	localparam logic [2:0] EV_BAD7    = 3'd7;

	// MIDI status nibbles.
	localparam logic [7:0] MIDI_NOTE_ON = 8'h90;
	localparam logic [7:0] MIDI_CTRL    = 8'hB0;
	localparam logic [7:0] MIDI_PROGRAM = 8'hC0;
	localparam logic [7:0] MIDI_BEND    = 8'hE0;

	// Plan kinds handed from datapath to controller.
	localparam logic [2:0] PK_NONE   = 3'd0;
	localparam logic [2:0] PK_SINGLE = 3'd1;
	localparam logic [2:0] PK_PREFIX = 3'd2;
	localparam logic [2:0] PK_EVENT  = 3'd3;
	localparam logic [2:0] PK_END    = 3'd4;

	// Output byte selects.
	localparam logic [2:0] SEL_SINGLE = 3'd0;
	localparam logic [2:0] SEL_PREFIX = 3'd1;
	localparam logic [2:0] SEL_VLQ    = 3'd2;
	localparam logic [2:0] SEL_STAT   = 3'd3;
	localparam logic [2:0] SEL_D1     = 3'd4;
	localparam logic [2:0] SEL_D2     = 3'd5;
	localparam logic [2:0] SEL_END    = 3'd6;

	localparam int PREFIX_LEN = 13;

	typedef struct packed {
		logic       load;
		logic       emit;
		logic [2:0] sel;
		logic [5:0] idx;
		logic       last;
	} mtm_cmd_t;

	typedef struct packed {
		logic        out_free;
		logic [2:0]  pk;
		logic [2:0]  vlq_n;
		logic        need_stat;
		logic        two;
		logic [15:0] used;
	} mtm_stat_t;

	function automatic logic [7:0] prefix_byte(input logic [3:0] i);
		case (i)
			4'd1:    prefix_byte = 8'hFF;
			4'd2:    prefix_byte = 8'h59;
			4'd3:    prefix_byte = 8'h02;
			4'd7:    prefix_byte = 8'hFF;
			4'd8:    prefix_byte = 8'h51;
			4'd9:    prefix_byte = 8'h03;
			4'd10:   prefix_byte = 8'h09;
			4'd11:   prefix_byte = 8'hA3;
			4'd12:   prefix_byte = 8'h1A;
			default: prefix_byte = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] end_byte(input logic [1:0] i);
		case (i)
			2'd1:    end_byte = 8'hFF;
			2'd2:    end_byte = 8'h2F;
			default: end_byte = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] ctl_map(input logic [3:0] i);
		case (i)
			4'd2:    ctl_map = 8'h01;
			4'd3:    ctl_map = 8'h07;
			4'd4:    ctl_map = 8'h0A;
			4'd5:    ctl_map = 8'h0B;
			4'd6:    ctl_map = 8'h5B;
			4'd7:    ctl_map = 8'h5D;
			4'd8:    ctl_map = 8'h40;
			4'd9:    ctl_map = 8'h43;
			4'd10:   ctl_map = 8'h78;
			4'd11:   ctl_map = 8'h7B;
			4'd12:   ctl_map = 8'h7E;
			4'd13:   ctl_map = 8'h7F;
			4'd14:   ctl_map = 8'h79;
			default: ctl_map = 8'h00;
		endcase
	endfunction

	// Channels 9 and 15 trade places; the rest map straight through.
	function automatic logic [3:0] chan_map(input logic [3:0] c);
		case (c)
			4'd9:    chan_map = 4'd15;
			4'd15:   chan_map = 4'd9;
			default: chan_map = c;
		endcase
	endfunction

endpackage

>>> design/mtm_in_if.sv
interface mtm_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] score_byte;

	modport source(output valid, output action, output score_byte, input ready);
	modport sink(input valid, input action, input score_byte, output ready);
endinterface

>>> design/mtm_out_if.sv
interface mtm_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] track;
	logic [7:0] midi_byte;
	logic [2:0] status;
	logic       last;

	modport source(output valid, output track, output midi_byte, output status, output last,
		input ready);
	modport sink(input valid, input track, input midi_byte, input status, input last,
		output ready);
endinterface

>>> design/mtm_datapath.sv
module mtm_datapath #(
	parameter int TIME_BITS = 28
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [15:0]       cfg_wdata,
	input  logic [1:0]        in_action,
	input  logic [7:0]        in_byte,
	input  mtm_pkg::mtm_cmd_t cmd,
	output mtm_pkg::mtm_stat_t status,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [3:0]        out_track,
	output logic [7:0]        out_byte,
	output logic [2:0]        out_status,
	output logic              out_last
);
	import mtm_pkg::*;

	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	logic [15:0] ic_q;
	logic        nc_q;

	logic [1:0]           phase_q, phase_n;
	logic [2:0]           kind_q, kind_n;
	logic [3:0]           ch_q, ch_n;
	logic                 lig_q, lig_n;
	logic [7:0]           fo_q, fo_n;
	logic [TIME_BITS-1:0] acc_q, acc_n;
	logic [TIME_BITS-1:0] time_q [TRACKS];
	logic [TIME_BITS-1:0] time_n [TRACKS];
	logic [6:0]           vel_q [TRACKS];
	logic [6:0]           vel_n [TRACKS];
	logic [7:0]           rs_q [TRACKS];
	logic [7:0]           rs_n [TRACKS];
	logic [15:0]          used_q, used_n;
	logic                 halted_q, halted_n;
	logic                 fin_q, fin_n;

	logic [2:0]           pk_q, pk_n;
	logic [2:0]           code_q, code_n;
	logic [TIME_BITS-1:0] v_q, v_n;
	logic [2:0]           n_q, n_n;
	logic [7:0]           stat_q, stat_n;
	logic                 need_q, need_n;
	logic                 two_q, two_n;
	logic [7:0]           d1_q, d1_n;
	logic [7:0]           d2_q, d2_n;
	logic [3:0]           trk_q, trk_n;

	logic                 out_valid_q;
	logic [3:0]           out_track_q;
	logic [7:0]           out_byte_q;
	logic [2:0]           out_status_q;
	logic                 out_last_q;

	logic [3:0]           trk;
	logic [TIME_BITS+6:0] acc_wide;
	logic [TIME_BITS-1:0] acc_new;
	logic [TIME_BITS-1:0] time_add [TRACKS];
	logic [TIME_BITS:0]   sum;
	logic                 ev, ev_force, ev_two;
	logic [7:0]           ev_kind, ev_d1, ev_d2, ev_stat;
	logic [TIME_BITS-1:0] tv;
	logic [2:0]           cnt_n;
	logic [TIME_BITS-1:0] vlq_sh;

	assign trk      = chan_map(ch_q);
	assign acc_wide = {acc_q, 7'b0} + {{TIME_BITS{1'b0}}, in_byte[6:0]};
	assign acc_new  = (acc_wide[TIME_BITS+6:TIME_BITS] != 7'd0) ? TIME_MAX
		: acc_wide[TIME_BITS-1:0];

	always_comb begin
		for (int i = 0; i < TRACKS; i++) begin
			sum = {1'b0, time_q[i]} + {1'b0, acc_new};
			time_add[i] = sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
		end
	end

	always_comb begin
		phase_n  = phase_q;
		kind_n   = kind_q;
		ch_n     = ch_q;
		lig_n    = lig_q;
		fo_n     = fo_q;
		acc_n    = acc_q;
		time_n   = time_q;
		vel_n    = vel_q;
		rs_n     = rs_q;
		used_n   = used_q;
		halted_n = halted_q;
		fin_n    = fin_q;
		pk_n     = pk_q;
		code_n   = code_q;
		v_n      = v_q;
		n_n      = n_q;
		stat_n   = stat_q;
		need_n   = need_q;
		two_n    = two_q;
		d1_n     = d1_q;
		d2_n     = d2_q;
		trk_n    = trk_q;
		ev       = 1'b0;
		ev_force = 1'b0;
		ev_two   = 1'b1;
		ev_kind  = MIDI_NOTE_ON;
		ev_d1    = 8'd0;
		ev_d2    = 8'd0;
		ev_stat  = 8'd0;
		tv       = '0;
		cnt_n    = 3'd1;
		if (cmd.load) begin
			pk_n = PK_NONE;
			if (in_action == ACT_START) begin
				phase_n  = PH_EVENT;
				kind_n   = 3'd0;
				ch_n     = 4'd0;
				lig_n    = 1'b0;
				fo_n     = 8'd0;
				acc_n    = '0;
				for (int i = 0; i < TRACKS; i++) begin
					time_n[i] = '0;
					vel_n[i]  = 7'd64;
					rs_n[i]   = 8'd0;
				end
				used_n   = 16'd1;
				fin_n    = 1'b0;
				halted_n = 1'b0;
				pk_n     = PK_PREFIX;
			end else if (in_action != ACT_BYTE && in_action != ACT_END) begin
				pk_n   = PK_SINGLE;
				code_n = ST_IGNORED;
			end else if (halted_q) begin
				pk_n   = PK_SINGLE;
				code_n = fin_q ? ST_FINISHED : ST_IGNORED;
			end else if (in_action == ACT_END) begin
				pk_n     = PK_SINGLE;
				code_n   = ST_NO_END;
				halted_n = 1'b1;
			end else begin
				case (phase_q)
					PH_EVENT: begin
						kind_n = in_byte[6:4];
						ch_n   = in_byte[3:0];
						lig_n  = in_byte[7];
						if (in_byte[6:4] == EV_SCOREND) begin
							pk_n     = PK_END;
							halted_n = 1'b1;
							fin_n    = 1'b1;
						end else if (in_byte[6:4] == EV_BAD5 || in_byte[6:4] == EV_BAD7) begin
							pk_n     = PK_SINGLE;
							code_n   = ST_ILLEGAL;
							halted_n = 1'b1;
						end else begin
							phase_n = PH_OP1;
						end
					end
					PH_OP1: begin
						fo_n = in_byte;
						case (kind_q)
							EV_RELEASE: begin
								ev       = 1'b1;
								ev_force = 1'b1;
								ev_d1    = {1'b0, in_byte[6:0]};
							end
							EV_PLAY: begin
								if (in_byte[7]) begin
									phase_n = PH_OP2;
								end else begin
									ev    = 1'b1;
									ev_d1 = in_byte;
									ev_d2 = {1'b0, vel_q[trk]};
								end
							end
							EV_BEND: begin
								ev      = 1'b1;
								ev_kind = MIDI_BEND;
								ev_d1   = {1'b0, in_byte[0], 6'd0};
								ev_d2   = {1'b0, in_byte[7:1]};
							end
							EV_SYSTEM: begin
								if (in_byte < 8'd10 || in_byte > 8'd14) begin
									pk_n     = PK_SINGLE;
									code_n   = ST_BAD_SYS;
									halted_n = 1'b1;
								end else begin
									ev      = 1'b1;
									ev_kind = MIDI_CTRL;
									ev_d1   = ctl_map(in_byte[3:0]);
									ev_d2   = (in_byte == 8'd12) ? (ic_q[7:0] + 8'd1) : 8'd0;
								end
							end
							default: begin
								if (in_byte > 8'd9) begin
									pk_n     = PK_SINGLE;
									code_n   = ST_BAD_CTL;
									halted_n = 1'b1;
								end else begin
									phase_n = PH_OP2;
								end
							end
						endcase
					end
					PH_OP2: begin
						ev = 1'b1;
						if (kind_q == EV_PLAY) begin
							vel_n[trk] = in_byte[6:0];
							ev_d1      = {1'b0, fo_q[6:0]};
							ev_d2      = {1'b0, in_byte[6:0]};
						end else if (fo_q == 8'd0) begin
							ev_kind = MIDI_PROGRAM;
							ev_two  = 1'b0;
							ev_d1   = {1'b0, in_byte[6:0]};
						end else begin
							ev_kind = MIDI_CTRL;
							ev_d1   = ctl_map(fo_q[3:0]);
							ev_d2   = {1'b0, in_byte[6:0]};
						end
					end
					default: begin
						acc_n = acc_new;
						if (!in_byte[7]) begin
							time_n  = time_add;
							acc_n   = '0;
							phase_n = PH_EVENT;
						end
					end
				endcase
			end
			if (ev) begin
				tv = time_q[trk];
				for (int k = 1; k < 5; k++) begin
					if ((tv >> (7 * k)) != '0) cnt_n = cnt_n + 3'd1;
				end
				ev_stat    = ev_kind | {4'd0, trk};
				pk_n       = PK_EVENT;
				v_n        = tv;
				n_n        = cnt_n;
				stat_n     = ev_stat;
				need_n     = ev_force || nc_q || (rs_q[trk] != ev_stat);
				two_n      = ev_two;
				d1_n       = ev_d1;
				d2_n       = ev_d2;
				trk_n      = trk;
				time_n[trk] = '0;
				rs_n[trk]  = ev_stat;
				used_n[trk] = 1'b1;
				if (lig_q) begin
					acc_n   = '0;
					phase_n = PH_TIME;
				end else begin
					phase_n = PH_EVENT;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ic_q     <= 16'd0;
			nc_q     <= 1'b0;
			phase_q  <= PH_EVENT;
			kind_q   <= 3'd0;
			ch_q     <= 4'd0;
			lig_q    <= 1'b0;
			fo_q     <= 8'd0;
			acc_q    <= '0;
			for (int i = 0; i < TRACKS; i++) begin
				time_q[i] <= '0;
				vel_q[i]  <= 7'd64;
				rs_q[i]   <= 8'd0;
			end
			used_q   <= 16'd0;
			halted_q <= 1'b1;
			fin_q    <= 1'b0;
			pk_q     <= PK_NONE;
		end else begin
			if (cfg_we) begin
				if (cfg_index) nc_q <= cfg_wdata[0];
				else ic_q <= cfg_wdata;
			end
			phase_q  <= phase_n;
			kind_q   <= kind_n;
			ch_q     <= ch_n;
			lig_q    <= lig_n;
			fo_q     <= fo_n;
			acc_q    <= acc_n;
			time_q   <= time_n;
			vel_q    <= vel_n;
			rs_q     <= rs_n;
			used_q   <= used_n;
			halted_q <= halted_n;
			fin_q    <= fin_n;
			pk_q     <= pk_n;
		end
	end

	always_ff @(posedge clk) begin
		code_q <= code_n;
		v_q    <= v_n;
		n_q    <= n_n;
		stat_q <= stat_n;
		need_q <= need_n;
		two_q  <= two_n;
		d1_q   <= d1_n;
		d2_q   <= d2_n;
		trk_q  <= trk_n;
	end

	assign vlq_sh = v_q >> (7 * int'(cmd.idx[2:0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_last_q <= cmd.last;
			case (cmd.sel)
				SEL_SINGLE: begin
					out_track_q  <= 4'd0;
					out_byte_q   <= 8'd0;
					out_status_q <= code_q;
				end
				SEL_PREFIX: begin
					out_track_q  <= 4'd0;
					out_byte_q   <= prefix_byte(cmd.idx[3:0]);
					out_status_q <= ST_DATA;
				end
				SEL_VLQ: begin
					out_track_q  <= trk_q;
					out_byte_q   <= {cmd.idx[2:0] != 3'd0, vlq_sh[6:0]};
					out_status_q <= ST_DATA;
				end
				SEL_STAT: begin
					out_track_q  <= trk_q;
					out_byte_q   <= stat_q;
					out_status_q <= ST_DATA;
				end
				SEL_D1: begin
					out_track_q  <= trk_q;
					out_byte_q   <= d1_q;
					out_status_q <= ST_DATA;
				end
				SEL_D2: begin
					out_track_q  <= trk_q;
					out_byte_q   <= d2_q;
					out_status_q <= ST_DATA;
				end
				default: begin
					out_track_q  <= cmd.idx[5:2];
					out_byte_q   <= end_byte(cmd.idx[1:0]);
					out_status_q <= ST_DATA;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign out_track  = out_track_q;
	assign out_byte   = out_byte_q;
	assign out_status = out_status_q;
	assign out_last   = out_last_q;

	assign status.out_free  = !out_valid_q || out_ready;
	assign status.pk        = pk_q;
	assign status.vlq_n     = n_q;
	assign status.need_stat = need_q;
	assign status.two       = two_q;
	assign status.used      = used_q;

endmodule

>>> design/mtm_controller.sv
module mtm_controller (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  mtm_pkg::mtm_stat_t status,
	output mtm_pkg::mtm_cmd_t  cmd
);
	import mtm_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_PLAN   = 4'd1;
	localparam logic [3:0] S_SINGLE = 4'd2;
	localparam logic [3:0] S_PREFIX = 4'd3;
	localparam logic [3:0] S_VLQ    = 4'd4;
	localparam logic [3:0] S_STAT   = 4'd5;
	localparam logic [3:0] S_D1     = 4'd6;
	localparam logic [3:0] S_D2     = 4'd7;
	localparam logic [3:0] S_END    = 4'd8;

	logic [3:0] state_q, state_n;
	logic [5:0] cnt_q, cnt_n;
	logic [3:0] t;
	logic       above;

	assign t = cnt_q[5:2];

	always_comb begin
		above = 1'b0;
		for (int j = 0; j < TRACKS; j++) begin
			if (j > int'(t) && status.used[j]) above = 1'b1;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_n  = state_q;
		cnt_n    = cnt_q;
		cmd      = '0;
		cmd.load = in_valid && in_ready;
		cmd.idx  = cnt_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.load) state_n = S_PLAN;
			end
			S_PLAN: begin
				cnt_n = 6'd0;
				case (status.pk)
					PK_SINGLE: state_n = S_SINGLE;
					PK_PREFIX: state_n = S_PREFIX;
					PK_EVENT: begin
						state_n = S_VLQ;
						cnt_n   = {3'd0, status.vlq_n - 3'd1};
					end
					PK_END:    state_n = S_END;
					default:   state_n = S_IDLE;
				endcase
			end
			S_SINGLE: begin
				cmd.sel  = SEL_SINGLE;
				cmd.last = 1'b1;
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_n  = S_IDLE;
				end
			end
			S_PREFIX: begin
				cmd.sel  = SEL_PREFIX;
				cmd.last = (cnt_q == 6'(PREFIX_LEN - 1));
				if (status.out_free) begin
					cmd.emit = 1'b1;
					cnt_n    = cnt_q + 6'd1;
					if (cmd.last) state_n = S_IDLE;
				end
			end
			S_VLQ: begin
				cmd.sel = SEL_VLQ;
				if (status.out_free) begin
					cmd.emit = 1'b1;
					if (cnt_q == 6'd0) state_n = status.need_stat ? S_STAT : S_D1;
					else cnt_n = cnt_q - 6'd1;
				end
			end
			S_STAT: begin
				cmd.sel = SEL_STAT;
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_n  = S_D1;
				end
			end
			S_D1: begin
				cmd.sel  = SEL_D1;
				cmd.last = !status.two;
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_n  = status.two ? S_D2 : S_IDLE;
				end
			end
			S_D2: begin
				cmd.sel  = SEL_D2;
				cmd.last = 1'b1;
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_n  = S_IDLE;
				end
			end
			S_END: begin
				cmd.sel  = SEL_END;
				cmd.last = (cnt_q[1:0] == 2'd3) && !above;
				// Unused tracks are skipped one per cycle.
				if (!status.used[t]) begin
					if (t == 4'd15) state_n = S_IDLE;
					else cnt_n = cnt_q + 6'd4;
				end else if (status.out_free) begin
					cmd.emit = 1'b1;
					cnt_n    = cnt_q + 6'd1;
					if (cnt_q[1:0] == 2'd3 && (t == 4'd15 || !above)) state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= 6'd0;
		end else begin
			state_q <= state_n;
			cnt_q   <= cnt_n;
		end
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.out_free) else $error("emit into a full output register");
	a_load_plan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_PLAN) else $error("accepted item not planned");
	a_vlq_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_VLQ |-> cnt_q < 6'd5) else $error("delta time index out of range");

endmodule

>>> design/mus_to_midi_event_transcoder_unit.sv
// Channel   Dir  Payload
// in_ch     in   action[1:0], score_byte[7:0]
// out_ch    out  track[3:0], midi_byte[7:0], status[2:0], last
// cfg       in   cfg_we, cfg_index (0 instrument_count, 1 no_compression), cfg_wdata[15:0]
//
// One item at a time: accept, a planning state, then the result bytes, each sent when
// the output is free; an event sends delta-time bytes, status when needed, then data.
// Score end walks tracks up to the last used one, four end bytes per used track.
// Reset halts the block until a start item; not all registers are reset.
// A stalled output holds its byte in the output register and the controller waits.
module mus_to_midi_event_transcoder_unit #(
	parameter int TIME_BITS = 28
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [15:0]   cfg_wdata,
	mtm_in_if.sink        in_ch,
	mtm_out_if.source     out_ch
);
	import mtm_pkg::*;

	mtm_cmd_t  cmd;
	mtm_stat_t status;

	mtm_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.status   (status),
		.cmd      (cmd)
	);

	mtm_datapath #(.TIME_BITS(TIME_BITS)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_action  (in_ch.action),
		.in_byte    (in_ch.score_byte),
		.cmd        (cmd),
		.status     (status),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.out_track  (out_ch.track),
		.out_byte   (out_ch.midi_byte),
		.out_status (out_ch.status),
		.out_last   (out_ch.last)
	);

endmodule
